// File: src/atrs_pkg.sv
// Package for the average true range smoother.
// Holds widths, the sequencer state type and the divider status struct.
// No dependencies.
`timescale 1ns / 1ps

package atrs_pkg;

   localparam int PRICE_WIDTH     = 32;
   localparam int WINDOW_WIDTH    = 11;
   localparam int MAX_WINDOW      = 1024;
   localparam int WINDOW_RESET    = 14;
   localparam int ACC_WIDTH       = PRICE_WIDTH + WINDOW_WIDTH;
   localparam int DIV_COUNT_WIDTH = $clog2(PRICE_WIDTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RANGE,
      ST_MULT,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: src/atrs_if.sv
// Valid/ready channel interfaces for bars in and results out.
// Depends on atrs_pkg for the field widths.
`timescale 1ns / 1ps

interface atrs_req_if import atrs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [PRICE_WIDTH-1:0] close_price;
   logic [PRICE_WIDTH-1:0] high_price;
   logic [PRICE_WIDTH-1:0] low_price;
   logic                   series_start;

   modport source (output valid, output close_price, output high_price,
                   output low_price, output series_start, input ready);
   modport sink   (input valid, input close_price, input high_price,
                   input low_price, input series_start, output ready);
endinterface

interface atrs_rsp_if import atrs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [PRICE_WIDTH-1:0] atr_value;
   logic [PRICE_WIDTH-1:0] true_range_value;
   logic                   warmed_up;

   modport source (output valid, output atr_value, output true_range_value,
                   output warmed_up, input ready);
   modport sink   (input valid, input atr_value, input true_range_value,
                   input warmed_up, output ready);
endinterface

// File: src/atrs_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on atrs_pkg; the quotient must fit in PRICE_WIDTH bits.
`timescale 1ns / 1ps

module atrs_divider import atrs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [ACC_WIDTH-1:0]    dividend,
   input  logic [WINDOW_WIDTH-1:0] divisor,
   output div_status_type          status,
   output logic [PRICE_WIDTH-1:0]  quotient
);

   logic [DIV_COUNT_WIDTH-1:0] count_ff, count_in;
   logic [WINDOW_WIDTH-1:0]    rem_ff, rem_in;
   logic [PRICE_WIDTH-1:0]     quo_ff, quo_in;
   logic [WINDOW_WIDTH:0]      trial;
   logic [WINDOW_WIDTH:0]      trial_sub;

   assign trial     = {rem_ff, quo_ff[PRICE_WIDTH-1]};
   assign trial_sub = trial - {1'b0, divisor};

   always_comb begin
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (start) begin
         // The upper bits are below the divisor, so they seed the remainder.
         count_in = DIV_COUNT_WIDTH'(PRICE_WIDTH);
         rem_in   = dividend[ACC_WIDTH-1:PRICE_WIDTH];
         quo_in   = dividend[PRICE_WIDTH-1:0];
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial_sub[WINDOW_WIDTH-1:0];
            quo_in = {quo_ff[PRICE_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[WINDOW_WIDTH-1:0];
            quo_in = {quo_ff[PRICE_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.busy = (count_ff != '0);
   assign status.done = (count_ff == DIV_COUNT_WIDTH'(1));
   assign quotient    = quo_ff;

endmodule

// File: src/average_true_range_smoother_core.sv
// Wilder average true range smoother. Each bar transfer is accepted in the idle
// state, its true range is formed on a single shared absolute-difference unit,
// then, once the series is warmed up, it passes a multiply state and a radix-2
// divider, and last the result register is loaded.
// The input is not ready while a bar is in work; a finished result waits in
// the output register while the next bar is accepted.
// Depends on atrs_pkg, atrs_if and atrs_divider.
`timescale 1ns / 1ps

module average_true_range_smoother_core import atrs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   atrs_req_if.sink                req_bus,
   atrs_rsp_if.source              rsp_bus,
   input  logic                    csr_write_enable,
   input  logic [WINDOW_WIDTH-1:0] csr_write_data
);

   localparam logic [1:0] RANGE_STEP_FIRST = 2'd0;
   localparam logic [1:0] RANGE_STEP_LAST  = 2'd2;

   state_type state_ff, state_in;

   logic [WINDOW_WIDTH-1:0] window_ff;
   logic [PRICE_WIDTH-1:0]  last_close_ff;
   logic [PRICE_WIDTH-1:0]  last_average_ff;
   logic [WINDOW_WIDTH-1:0] bars_seen_ff, bars_seen_in;
   logic                    have_close_ff;

   logic [PRICE_WIDTH-1:0]  close_ff, high_ff, low_ff;
   logic                    have_prev_ff;
   logic                    warm_ff, warm_in;
   logic [PRICE_WIDTH-1:0]  base_avg_ff;
   logic [1:0]              step_ff;
   logic [PRICE_WIDTH-1:0]  tr_ff;

   logic                    rsp_valid_ff;
   logic [PRICE_WIDTH-1:0]  rsp_atr_ff, rsp_tr_ff;
   logic                    rsp_warm_ff;

   logic [WINDOW_WIDTH-1:0] eff_window;
   logic [WINDOW_WIDTH-1:0] base_bars;
   logic [PRICE_WIDTH-1:0]  abs_a, abs_b, abs_diff;
   logic [ACC_WIDTH-1:0]    mult_acc;
   logic [PRICE_WIDTH-1:0]  avg_result;
   logic                    accept, range_end, load_rsp;
   logic                    div_start;
   div_status_type          div_status;
   logic [PRICE_WIDTH-1:0]  div_quotient;

   // A window of zero acts as one; anything above the maximum is clamped.
   always_comb begin
      priority if (window_ff == '0) begin
         eff_window = WINDOW_WIDTH'(1);
      end else if (window_ff > WINDOW_WIDTH'(MAX_WINDOW)) begin
         eff_window = WINDOW_WIDTH'(MAX_WINDOW);
      end else begin
         eff_window = window_ff;
      end
   end

   assign accept    = req_bus.valid && req_bus.ready;
   assign base_bars = req_bus.series_start ? '0 : bars_seen_ff;

   always_comb begin
      bars_seen_in = base_bars;
      if (base_bars < eff_window) begin
         bars_seen_in = base_bars + 1'b1;
      end
      warm_in = (bars_seen_in >= eff_window);
   end

   // Shared absolute-difference unit: high-low, then high and low against
   // the previous close.
   always_comb begin
      unique case (step_ff)
         RANGE_STEP_FIRST: begin
            abs_a = high_ff;
            abs_b = low_ff;
         end
         2'd1: begin
            abs_a = high_ff;
            abs_b = last_close_ff;
         end
         default: begin
            abs_a = low_ff;
            abs_b = last_close_ff;
         end
      endcase
      abs_diff = (abs_a >= abs_b) ? (abs_a - abs_b) : (abs_b - abs_a);
   end

   assign range_end = (step_ff == RANGE_STEP_LAST) ||
                      (step_ff == RANGE_STEP_FIRST && !have_prev_ff);

   assign mult_acc = {{PRICE_WIDTH{1'b0}}, eff_window - 1'b1} *
                     {{WINDOW_WIDTH{1'b0}}, base_avg_ff} +
                     {{WINDOW_WIDTH{1'b0}}, tr_ff};

   atrs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mult_acc),
      .divisor  (eff_window),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign avg_result = warm_ff ? div_quotient : '0;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            if (range_end) begin
               state_in = warm_ff ? ST_MULT : ST_DONE;
            end
         end
         ST_MULT: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_bus.ready = 1'b0;
      div_start     = 1'b0;
      load_rsp      = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_bus.ready = 1'b1;
         ST_MULT:   div_start     = 1'b1;
         ST_DONE:   load_rsp      = !rsp_valid_ff || rsp_bus.ready;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         window_ff       <= WINDOW_WIDTH'(WINDOW_RESET);
         last_close_ff   <= '0;
         last_average_ff <= '0;
         bars_seen_ff    <= '0;
         have_close_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         step_ff         <= RANGE_STEP_FIRST;
         warm_ff         <= 1'b0;
         have_prev_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            window_ff <= csr_write_data;
         end
         if (accept) begin
            bars_seen_ff <= bars_seen_in;
            warm_ff      <= warm_in;
            have_prev_ff <= have_close_ff && !req_bus.series_start;
            step_ff      <= RANGE_STEP_FIRST;
         end else if (state_ff == ST_RANGE && !range_end) begin
            step_ff <= step_ff + 1'b1;
         end
         if (load_rsp) begin
            last_average_ff <= avg_result;
            last_close_ff   <= close_ff;
            have_close_ff   <= 1'b1;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         close_ff    <= req_bus.close_price;
         high_ff     <= req_bus.high_price;
         low_ff      <= req_bus.low_price;
         base_avg_ff <= req_bus.series_start ? '0 : last_average_ff;
      end
      if (state_ff == ST_RANGE) begin
         if (step_ff == RANGE_STEP_FIRST || abs_diff > tr_ff) begin
            tr_ff <= abs_diff;
         end
      end
      if (load_rsp) begin
         rsp_atr_ff  <= avg_result;
         rsp_tr_ff   <= tr_ff;
         rsp_warm_ff <= warm_ff;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.atr_value        = rsp_atr_ff;
   assign rsp_bus.true_range_value = rsp_tr_ff;
   assign rsp_bus.warmed_up        = rsp_warm_ff;

endmodule

// File: src/atrs_checker.sv
// Port-level checks for the average true range smoother.
// Depends on atrs_pkg; bound to average_true_range_smoother_core below.
`timescale 1ns / 1ps

module atrs_checker import atrs_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [PRICE_WIDTH-1:0] atr_value,
   input logic [PRICE_WIDTH-1:0] true_range_value,
   input logic                   warmed_up
);

   // The block works on one bar at a time, so it is busy after a transfer.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after an input transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !warmed_up |-> atr_value == '0)
      else $error("nonzero average during warm-up");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(atr_value) && $stable(true_range_value) && $stable(warmed_up))
      else $error("result changed while stalled");

endmodule

bind average_true_range_smoother_core atrs_checker u_atrs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .atr_value        (rsp_bus.atr_value),
   .true_range_value (rsp_bus.true_range_value),
   .warmed_up        (rsp_bus.warmed_up)
);

// File: tb/sv/average_true_range_smoother_core_tb.sv
// Self-checking testbench for average_true_range_smoother_core.
// Drives price bars and window writes, predicts every result in a scoreboard
// class and compares it with each result transfer. Depends on atrs_pkg, atrs_if and the core.
`timescale 1ns / 1ps

module average_true_range_smoother_core_tb;
   import atrs_pkg::*;

   typedef struct packed {
      logic [PRICE_WIDTH-1:0] close_price;
      logic [PRICE_WIDTH-1:0] high_price;
      logic [PRICE_WIDTH-1:0] low_price;
      logic                   series_start;
   } bar_type;

   typedef struct packed {
      logic [PRICE_WIDTH-1:0] atr_value;
      logic [PRICE_WIDTH-1:0] true_range_value;
      logic                   warmed_up;
   } atr_result_type;

   localparam int STALL_LIMIT    = 3000;
   localparam int RANDOM_BARS    = 1200;
   localparam int MAX_GAP        = 10;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [PRICE_WIDTH-1:0] PRICE_TOP = '1;

   class atr_scoreboard;
      logic [WINDOW_WIDTH-1:0] window_reg;
      logic [PRICE_WIDTH-1:0]  prev_close;
      logic [PRICE_WIDTH-1:0]  prev_average;
      logic [WINDOW_WIDTH-1:0] bar_count;
      bit                      have_close;
      atr_result_type          expected_q[$];
      int                      mismatches;
      int                      bars_noted;
      int                      results_checked;
      int                      warm_results;
      int                      series_starts;

      function new();
         window_reg      = WINDOW_WIDTH'(WINDOW_RESET);
         prev_close      = '0;
         prev_average    = '0;
         bar_count       = '0;
         have_close      = 0;
         mismatches      = 0;
         bars_noted      = 0;
         results_checked = 0;
         warm_results    = 0;
         series_starts   = 0;
      endfunction

      function void set_window(logic [WINDOW_WIDTH-1:0] value);
         window_reg = value;
      endfunction

      function logic [PRICE_WIDTH-1:0] spread_between(logic [PRICE_WIDTH-1:0] a,
                                                      logic [PRICE_WIDTH-1:0] b);
         return (a >= b) ? a - b : b - a;
      endfunction

      // Computes the expected result of an accepted bar and queues it.
      function void note_bar(bar_type bar);
         int unsigned            divisor;
         logic [PRICE_WIDTH-1:0] range_now;
         logic [PRICE_WIDTH-1:0] side;
         logic [63:0]            acc;
         atr_result_type         want;
         divisor = 32'(window_reg);
         if (divisor == 0) divisor = 1;
         if (divisor > MAX_WINDOW) divisor = MAX_WINDOW;
         bars_noted++;
         if (bar.series_start) begin
            series_starts++;
            bar_count    = '0;
            prev_average = '0;
            have_close   = 0;
         end
         range_now = spread_between(bar.high_price, bar.low_price);
         if (have_close) begin
            side = spread_between(bar.high_price, prev_close);
            if (side > range_now) range_now = side;
            side = spread_between(bar.low_price, prev_close);
            if (side > range_now) range_now = side;
         end
         // The count stops at the window, but a window lowered mid-series can
         // leave it above the new window, which still counts as warmed up.
         if (bar_count < divisor) bar_count++;
         want.warmed_up        = (bar_count >= divisor);
         want.true_range_value = range_now;
         want.atr_value        = '0;
         if (want.warmed_up) begin
            acc = 64'(divisor - 1) * 64'(prev_average) + 64'(range_now);
            acc = acc / 64'(divisor);
            want.atr_value = (acc > 64'(PRICE_TOP)) ? PRICE_TOP : acc[PRICE_WIDTH-1:0];
         end
         prev_average = want.atr_value;
         prev_close   = bar.close_price;
         have_close   = 1;
         expected_q.push_back(want);
      endfunction

      function void check_result(atr_result_type got);
         atr_result_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("Result with no bar pending: atr %h tr %h warm %0b",
                        got.atr_value, got.true_range_value, got.warmed_up);
            return;
         end
         want = expected_q.pop_front();
         results_checked++;
         if (want.warmed_up) warm_results++;
         if (got.atr_value !== want.atr_value
             || got.true_range_value !== want.true_range_value
             || got.warmed_up !== want.warmed_up) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"Result %0d differs: expected atr %h tr %h warm %0b, ",
                         "got atr %h tr %h warm %0b"},
                        results_checked, want.atr_value, want.true_range_value,
                        want.warmed_up, got.atr_value, got.true_range_value,
                        got.warmed_up);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    csr_write_enable;
   logic [WINDOW_WIDTH-1:0] csr_write_data;

   atrs_req_if req_bus ();
   atrs_rsp_if rsp_bus ();

   atr_scoreboard          atr_board;
   bit                     steady_flow;
   int                     window_writes;
   int                     random_sent;
   logic [PRICE_WIDTH-1:0] price_level;

   average_true_range_smoother_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic bar_type bar_of(logic [PRICE_WIDTH-1:0] close_price,
                                      logic [PRICE_WIDTH-1:0] high_price,
                                      logic [PRICE_WIDTH-1:0] low_price,
                                      logic series_start);
      bar_type bar;
      bar.close_price  = close_price;
      bar.high_price   = high_price;
      bar.low_price    = low_price;
      bar.series_start = series_start;
      return bar;
   endfunction

   // Mostly a drifting market with bars of random width around the current
   // level; the rest are unrelated prices, often with low above high.
   function automatic bar_type random_bar();
      bar_type                bar;
      logic [PRICE_WIDTH-1:0] mask;
      logic [PRICE_WIDTH-1:0] step;
      logic [PRICE_WIDTH-1:0] up_move;
      logic [PRICE_WIDTH-1:0] down_move;
      logic [PRICE_WIDTH:0]   span;
      bar.series_start = ($urandom_range(0, 19) == 0);
      if (bar.series_start) begin
         case ($urandom_range(0, 3))
            0:       price_level = '0;
            1:       price_level = PRICE_TOP;
            default: price_level = $urandom;
         endcase
      end
      if ($urandom_range(0, 4) == 0) begin
         bar.close_price = $urandom;
         bar.high_price  = $urandom;
         bar.low_price   = $urandom;
      end else begin
         mask = PRICE_TOP >> $urandom_range(8, 31);
         step = $urandom & mask;
         if ($urandom_range(0, 1))
            price_level = (price_level > PRICE_TOP - step) ? PRICE_TOP : price_level + step;
         else
            price_level = (price_level < step) ? '0 : price_level - step;
         up_move        = $urandom & mask;
         down_move      = $urandom & mask;
         bar.high_price = (price_level > PRICE_TOP - up_move) ? PRICE_TOP
                                                              : price_level + up_move;
         bar.low_price  = (price_level < down_move) ? '0 : price_level - down_move;
         span = {1'b0, bar.high_price - bar.low_price} + 1'b1;
         bar.close_price = bar.low_price + PRICE_WIDTH'({1'b0, 32'($urandom)} % span);
      end
      return bar;
   endfunction

   task automatic send_bar(bar_type bar);
      int unsigned gap;
      gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.close_price  <= bar.close_price;
      req_bus.high_price   <= bar.high_price;
      req_bus.low_price    <= bar.low_price;
      req_bus.series_start <= bar.series_start;
      do @(posedge clock); while (!req_bus.ready);
      atr_board.note_bar(bar);
   endtask

   // The window is only changed once every outstanding result has come back.
   task automatic write_window(logic [WINDOW_WIDTH-1:0] value);
      req_bus.valid <= 1'b0;
      while (atr_board.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      atr_board.set_window(value);
      window_writes++;
   endtask

   initial begin
      int unsigned             phase_bars;
      logic [WINDOW_WIDTH-1:0] window_pick;
      atr_board     = new();
      steady_flow   = 0;
      window_writes = 0;
      random_sent   = 0;
      price_level   = 32'h0064_0000;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.close_price  <= '0;
      req_bus.high_price   <= '0;
      req_bus.low_price    <= '0;
      req_bus.series_start <= 1'b0;
      rsp_bus.ready        <= 1'b0;
      csr_write_enable     <= 1'b0;
      csr_write_data       <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset window. The first bar has no previous close even without a start.
      send_bar(bar_of(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 1'b0));
      send_bar(bar_of(PRICE_TOP, PRICE_TOP, '0, 1'b0));
      send_bar(bar_of('0, '0, '0, 1'b0));
      send_bar(bar_of(32'h0000_5000, 32'h0000_1000, 32'h0000_9000, 1'b1));
      send_bar(bar_of(32'h1234_5678, 32'h0000_0100, 32'h0000_0200, 1'b0));
      // The series already holds two bars, more than the new window.
      write_window(WINDOW_WIDTH'(1));
      send_bar(bar_of(PRICE_TOP, PRICE_TOP, PRICE_TOP, 1'b0));
      send_bar(bar_of('0, PRICE_TOP, '0, 1'b0));
      send_bar(bar_of(PRICE_TOP, '0, PRICE_TOP, 1'b1));
      write_window('0);
      send_bar(bar_of(32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFF, 1'b1));
      send_bar(bar_of('0, 32'h0000_0001, PRICE_TOP, 1'b0));
      write_window('1);
      send_bar(bar_of(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1));
      send_bar(bar_of(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0));
      send_bar(bar_of(PRICE_TOP, PRICE_TOP, '0, 1'b0));
      write_window(WINDOW_WIDTH'(MAX_WINDOW));
      send_bar(bar_of('0, PRICE_TOP, '0, 1'b1));
      send_bar(bar_of(PRICE_TOP, '0, '0, 1'b0));
      // A short window fed alternating extremes pushes the average towards the top.
      write_window(WINDOW_WIDTH'(2));
      send_bar(bar_of('0, PRICE_TOP, '0, 1'b1));
      send_bar(bar_of(PRICE_TOP, PRICE_TOP, PRICE_TOP, 1'b0));
      send_bar(bar_of('0, '0, '0, 1'b0));
      send_bar(bar_of(PRICE_TOP, PRICE_TOP, PRICE_TOP, 1'b0));
      send_bar(bar_of('0, '0, '0, 1'b0));

      while (random_sent < RANDOM_BARS) begin
         case ($urandom_range(0, 9))
            0:       window_pick = '0;
            1:       window_pick = WINDOW_WIDTH'(1);
            2:       window_pick = '1;
            3:       window_pick = WINDOW_WIDTH'(MAX_WINDOW);
            4:       window_pick = WINDOW_WIDTH'($urandom_range(0, 2047));
            default: window_pick = WINDOW_WIDTH'($urandom_range(1, 20));
         endcase
         write_window(window_pick);
         steady_flow = ($urandom_range(0, 3) == 0);
         phase_bars  = $urandom_range(40, 120);
         repeat (phase_bars) send_bar(random_bar());
         random_sent += phase_bars;
      end

      steady_flow = 0;
      req_bus.valid <= 1'b0;
      while (atr_board.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Ran %0d bars in %0d series over %0d window settings.",
               atr_board.bars_noted, atr_board.series_starts, window_writes);
      $display("Compared %0d results, %0d of them warmed up; %0d mismatches.",
               atr_board.results_checked, atr_board.warm_results, atr_board.mismatches);
      if (atr_board.mismatches == 0 && atr_board.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      atr_result_type got;
      int unsigned    stall;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got.atr_value        = rsp_bus.atr_value;
         got.true_range_value = rsp_bus.true_range_value;
         got.warmed_up        = rsp_bus.warmed_up;
         atr_board.check_result(got);
      end
   end

   // Ends the run if neither channel has moved a transfer for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
             || (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timeout: no transfer in %0d cycles, %0d results outstanding.",
               STALL_LIMIT, atr_board.pending());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
